FILE: sv/radar_spoke_polar_to_cartesian_macros.svh
// ----------------------------------------------------------------------------
// Radar spoke converter assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i, reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef RADAR_SPOKE_POLAR_TO_CARTESIAN_MACROS_SVH
`define RADAR_SPOKE_POLAR_TO_CARTESIAN_MACROS_SVH

// same-cycle implication
`define RSPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RSPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/rspc_pkg.sv
// ----------------------------------------------------------------------------
// Radar spoke converter package
// Constants, pipeline record and arctangent table shared by all stages.
// ----------------------------------------------------------------------------
package rspc_pkg;

  localparam int SPOKE_PIXELS = 1024;
  localparam int FULL_TURN    = 5760;
  localparam int QUARTER_TURN = 1440;
  localparam int CORDIC_STEPS = 16;
  localparam int DIV_STEPS    = 20;
  localparam int CORDIC_GAIN  = 652032874;

  typedef enum logic [1:0] {
    CFG_FLOOR  = 2'd0,
    CFG_OFFSET = 2'd1
  } cfg_idx_e;

  // one pipeline slot
  typedef struct packed {
    logic               valid;
    logic [10:0]        rem;    // partial remainder
    logic [19:0]        low;    // numerator bits in, quotient bits out
    logic [10:0]        den2;   // divisor
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [28:0] z;
    logic [1:0]         quad;
  } pipe_t;

  function automatic logic signed [28:0] atan_at(input int i);
    logic signed [28:0] v;
    case (i)
      0:       v = 29'sd47185920;
      1:       v = 29'sd27855475;
      2:       v = 29'sd14718068;
      3:       v = 29'sd7471121;
      4:       v = 29'sd3750058;
      5:       v = 29'sd1876857;
      6:       v = 29'sd938658;
      7:       v = 29'sd469357;
      8:       v = 29'sd234682;
      9:       v = 29'sd117342;
      10:      v = 29'sd58671;
      11:      v = 29'sd29335;
      12:      v = 29'sd14668;
      13:      v = 29'sd7334;
      14:      v = 29'sd3667;
      15:      v = 29'sd1833;
      default: v = 29'sd0;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/radar_spoke_polar_to_cartesian.sv
// ----------------------------------------------------------------------------
// Radar spoke polar to cartesian converter
// Turns radar spoke pixels into east/north points, one pixel per clock while the output is not held.
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------
//  in       | in_valid_i/in_ready_o | intensity, pixel_index, spoke_length,
//           |                       | spoke_angle, range_limit
//  out      | out_valid_o/out_ready_i | pos_x, pos_y
//  cfg      | cfg_we_i              | cfg_idx_i, cfg_data_i
//
//  One beat per clock while the output is not held. Stages: input stage, 20
//  cells (each cell one quotient bit of the range divide, the first 16 also one
//  CORDIC rotation), output stage. The 20-bit range quotient sets the depth.
//  Reset clears the valid bits and the config registers (floor 0, offset 0).
//  A held output beat freezes the whole pipe; in_ready_o drops with it.
//  Pixels below the floor travel as bubbles and give no output beat.
//
module radar_spoke_polar_to_cartesian (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          intensity_i,
  input  logic [9:0]          pixel_index_i,
  input  logic [10:0]         spoke_length_i,
  input  logic [12:0]         spoke_angle_i,
  input  logic [19:0]         range_limit_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [20:0]  pos_x_o,
  output logic signed [20:0]  pos_y_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [13:0]         cfg_data_i
);

  logic                advance;
  logic [7:0]          floor_q;
  logic signed [13:0]  offset_q;
  rspc_pkg::pipe_t     chain [0:rspc_pkg::DIV_STEPS];

  // pipe moves whenever the output slot is free or being drained
  assign advance    = !out_valid_o || out_ready_i;
  assign in_ready_o = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q  <= '0;
      offset_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rspc_pkg::CFG_FLOOR:  floor_q  <= cfg_data_i[7:0];
        rspc_pkg::CFG_OFFSET: offset_q <= $signed(cfg_data_i);
        default: ;  // unknown index: ignored
      endcase
    end
  end

  rspc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (advance),
    .in_valid_i     (in_valid_i),
    .intensity_i    (intensity_i),
    .pixel_index_i  (pixel_index_i),
    .spoke_length_i (spoke_length_i),
    .spoke_angle_i  (spoke_angle_i),
    .range_limit_i  (range_limit_i),
    .floor_i        (floor_q),
    .offset_i       (offset_q),
    .stage_o        (chain[0])
  );

  // row of cells: divide bit g, rotation g while g < CORDIC_STEPS
  for (genvar g = 0; g < rspc_pkg::DIV_STEPS; g++) begin : g_cell
    localparam bit ROT_ON = (g < rspc_pkg::CORDIC_STEPS);
    rspc_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (advance),
      .stage_i     (chain[g]),
      .atan_i      (rspc_pkg::atan_at(g)),
      .shift_i     (5'(g)),
      .cordic_on_i (ROT_ON),
      .stage_o     (chain[g+1])
    );
  end

  rspc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .stage_i     (chain[rspc_pkg::DIV_STEPS]),
    .out_valid_o (out_valid_o),
    .pos_x_o     (pos_x_o),
    .pos_y_o     (pos_y_o)
  );

endmodule

FILE: sv/rspc_front.sv
// ----------------------------------------------------------------------------
// Radar spoke converter input stage
// Intensity gate, range numerator/divisor setup and bearing reduction.
// ----------------------------------------------------------------------------
module rspc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                in_valid_i,
  input  logic [7:0]          intensity_i,
  input  logic [9:0]          pixel_index_i,
  input  logic [10:0]         spoke_length_i,
  input  logic [12:0]         spoke_angle_i,
  input  logic [19:0]         range_limit_i,
  input  logic [7:0]          floor_i,
  input  logic signed [13:0]  offset_i,
  output rspc_pkg::pipe_t     stage_o
);

  logic [10:0]        len_c;
  logic [9:0]         den_c;
  logic [9:0]         idx_c;
  logic [30:0]        num_c;
  logic signed [14:0] s0, s1, s2;
  logic [12:0]        ang_c;
  logic [1:0]         quad_c;
  logic [10:0]        rem_c;
  rspc_pkg::pipe_t    stage_d, stage_q;

  always_comb begin
    len_c = (spoke_length_i > 11'(rspc_pkg::SPOKE_PIXELS)) ?
            11'(rspc_pkg::SPOKE_PIXELS) : spoke_length_i;
    if (len_c >= 11'd2) begin
      den_c = 10'(len_c - 11'd1);
      idx_c = (pixel_index_i > den_c) ? den_c : pixel_index_i;
      num_c = 31'({range_limit_i, 1'b0}) * 31'(idx_c) + 31'(den_c);
    end else begin
      // short spoke: zero numerator gives range 0
      den_c = 10'd1;
      idx_c = 10'd0;
      num_c = 31'd0;
    end
  end

  always_comb begin
    s0 = $signed({2'b00, spoke_angle_i}) + 15'(offset_i);
    priority if (s0 < 0)                                 s1 = s0 + 15'(rspc_pkg::FULL_TURN);
    else if (s0 >= 15'(rspc_pkg::FULL_TURN))            s1 = s0 - 15'(rspc_pkg::FULL_TURN);
    else                                                 s1 = s0;
    priority if (s1 < 0)                                 s2 = s1 + 15'(rspc_pkg::FULL_TURN);
    else if (s1 >= 15'(rspc_pkg::FULL_TURN))            s2 = s1 - 15'(rspc_pkg::FULL_TURN);
    else                                                 s2 = s1;
    ang_c = s2[12:0];
    priority if (ang_c >= 13'(3 * rspc_pkg::QUARTER_TURN)) begin
      quad_c = 2'd3;
      rem_c  = 11'(ang_c - 13'(3 * rspc_pkg::QUARTER_TURN));
    end else if (ang_c >= 13'(2 * rspc_pkg::QUARTER_TURN)) begin
      quad_c = 2'd2;
      rem_c  = 11'(ang_c - 13'(2 * rspc_pkg::QUARTER_TURN));
    end else if (ang_c >= 13'(rspc_pkg::QUARTER_TURN)) begin
      quad_c = 2'd1;
      rem_c  = 11'(ang_c - 13'(rspc_pkg::QUARTER_TURN));
    end else begin
      quad_c = 2'd0;
      rem_c  = ang_c[10:0];
    end
  end

  always_comb begin
    stage_d.valid = in_valid_i && (intensity_i >= floor_i);
    stage_d.rem   = num_c[30:20];
    stage_d.low   = num_c[19:0];
    stage_d.den2  = {den_c, 1'b0};
    stage_d.x     = 33'(rspc_pkg::CORDIC_GAIN);
    stage_d.y     = '0;
    stage_d.z     = $signed(29'({rem_c, 16'b0}));
    stage_d.quad  = quad_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

FILE: sv/rspc_cell.sv
// ----------------------------------------------------------------------------
// Radar spoke converter cell
// One restoring-division bit per cell, plus one CORDIC rotation when cordic_on_i is set.
// ----------------------------------------------------------------------------
module rspc_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  rspc_pkg::pipe_t    stage_i,
  input  logic signed [28:0] atan_i,
  input  logic [4:0]         shift_i,
  input  logic               cordic_on_i,
  output rspc_pkg::pipe_t    stage_o
);

  logic [11:0]        trial;
  logic               ge;
  logic signed [32:0] dx, dy;
  rspc_pkg::pipe_t    stage_d, stage_q;

  always_comb begin
    stage_d = stage_i;
    trial   = {stage_i.rem, stage_i.low[19]};
    ge      = trial >= {1'b0, stage_i.den2};
    stage_d.rem = ge ? 11'(trial - {1'b0, stage_i.den2}) : trial[10:0];
    stage_d.low = {stage_i.low[18:0], ge};
    dx = stage_i.y >>> shift_i;
    dy = stage_i.x >>> shift_i;
    if (cordic_on_i) begin
      if (!stage_i.z[28]) begin
        stage_d.x = stage_i.x - dx;
        stage_d.y = stage_i.y + dy;
        stage_d.z = stage_i.z - atan_i;
      end else begin
        stage_d.x = stage_i.x + dx;
        stage_d.y = stage_i.y - dy;
        stage_d.z = stage_i.z + atan_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

FILE: sv/rspc_back.sv
// ----------------------------------------------------------------------------
// Radar spoke converter output stage
// Q0.15 rounding, quadrant mapping, range scaling and output register.
// ----------------------------------------------------------------------------
module rspc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  rspc_pkg::pipe_t     stage_i,
  output logic                out_valid_o,
  output logic signed [20:0]  pos_x_o,
  output logic signed [20:0]  pos_y_o
);

  function automatic logic [14:0] to_q15(input logic signed [32:0] v);
    logic signed [32:0] s;
    logic signed [17:0] r;
    logic [14:0]        q;
    s = v + 33'sd16384;
    r = 18'(s >>> 15);
    if (r < 0)                q = 15'd0;
    else if (r > 18'sd32767)  q = 15'd32767;
    else                      q = r[14:0];
    return q;
  endfunction

  function automatic logic [20:0] scale(input logic [19:0] rng, input logic [14:0] t,
                                        input logic neg);
    logic [34:0] p;
    logic [20:0] m;
    p = 35'(rng) * 35'(t) + 35'd16384;
    m = 21'(p >> 15);
    return neg ? (21'd0 - m) : m;
  endfunction

  logic [14:0]        sin_c, cos_c;
  logic [20:0]        x_d, y_d;
  logic               valid_q;
  logic signed [20:0] x_q, y_q;

  always_comb begin
    sin_c = to_q15(stage_i.y);
    cos_c = to_q15(stage_i.x);
    unique case (stage_i.quad)
      2'd0: begin
        x_d = scale(stage_i.low, sin_c, 1'b0);
        y_d = scale(stage_i.low, cos_c, 1'b0);
      end
      2'd1: begin
        x_d = scale(stage_i.low, cos_c, 1'b0);
        y_d = scale(stage_i.low, sin_c, 1'b1);
      end
      2'd2: begin
        x_d = scale(stage_i.low, sin_c, 1'b1);
        y_d = scale(stage_i.low, cos_c, 1'b1);
      end
      default: begin
        x_d = scale(stage_i.low, cos_c, 1'b1);
        y_d = scale(stage_i.low, sin_c, 1'b0);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= $signed(x_d);
      y_q <= $signed(y_d);
    end
  end

  assign out_valid_o = valid_q;
  assign pos_x_o     = x_q;
  assign pos_y_o     = y_q;

endmodule

FILE: sv/rspc_checker.sv
// ----------------------------------------------------------------------------
// Radar spoke converter port checker
// Watches the top-level ports for flow-control slips.
// ----------------------------------------------------------------------------
`include "radar_spoke_polar_to_cartesian_macros.svh"

module rspc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic signed [20:0]  pos_x_o,
  input logic signed [20:0]  pos_y_o
);

  `RSPC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(pos_x_o) && $stable(pos_y_o), "output beat changed while stalled")
  `RSPC_ASSERT_NOW(a_ready_free, !out_valid_o, in_ready_o, "input stalled with empty output slot")
  `RSPC_ASSERT_NOW(a_ready_stall, out_valid_o && !out_ready_i, !in_ready_o, "input taken while pipe frozen")

endmodule

bind radar_spoke_polar_to_cartesian rspc_checker u_rspc_checker (.*);
